FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that holds at every edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/tmes_pkg.sv
`default_nettype none
package tmes_pkg;

  localparam logic [8:0] MAX_LEN = 9'd256;

  localparam logic [7:0] CB_INT_EN = 8'h80;
  localparam logic [7:0] CB_BUS_EN = 8'h40;
  localparam logic [7:0] CB_START  = 8'h20;
  localparam logic [7:0] CB_STOP   = 8'h10;
  localparam logic [7:0] CB_IFLAG  = 8'h08;
  localparam logic [7:0] CB_ACK    = 8'h04;

  localparam logic [7:0] SC_START     = 8'h08;
  localparam logic [7:0] SC_RSTART    = 8'h10;
  localparam logic [7:0] SC_ADDR_W_AK = 8'h18;
  localparam logic [7:0] SC_ADDR_W_NK = 8'h20;
  localparam logic [7:0] SC_DATA_W_AK = 8'h28;
  localparam logic [7:0] SC_DATA_W_NK = 8'h30;
  localparam logic [7:0] SC_ADDR_R_AK = 8'h40;
  localparam logic [7:0] SC_ADDR_R_NK = 8'h48;
  localparam logic [7:0] SC_DATA_R_AK = 8'h50;
  localparam logic [7:0] SC_DATA_R_NK = 8'h58;
  localparam logic [7:0] SC_ADDR2_W   = 8'hd0;

  typedef enum logic [2:0] {
    EV_START = 3'd1,
    EV_WRITE = 3'd2,
    EV_READ  = 3'd3,
    EV_RNACK = 3'd4,
    EV_NODEV = 3'd5,
    EV_ERROR = 3'd6
  } ev_class_t;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic       mode;
    logic [7:0] slave_addr;
    logic       read_dir;
    logic [8:0] length;
    ev_class_t  ev_class;
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
  } tmes_item_t;

  typedef struct packed {
    logic       ctrl_write;
    logic [7:0] ctrl_value;
    logic       data_write;
    logic [8:0] data_value;
    logic       rx_store;
    logic [7:0] rx_index;
    logic [7:0] rx_value;
    logic       msg_done;
    logic       msg_ok;
    logic       bus_reinit;
  } tmes_result_t;

  function automatic ev_class_t classify(input logic [7:0] code);
    ev_class_t c;
    case (code)
      SC_START, SC_RSTART:                     c = EV_START;
      SC_ADDR_W_AK, SC_DATA_W_AK, SC_ADDR2_W:  c = EV_WRITE;
      SC_ADDR_R_AK, SC_DATA_R_AK:              c = EV_READ;
      SC_DATA_R_NK:                            c = EV_RNACK;
      SC_ADDR_W_NK, SC_DATA_W_NK, SC_ADDR_R_NK: c = EV_NODEV;
      default:                                 c = EV_ERROR;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/tmes_front.sv
`default_nettype none
module tmes_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 mode,
  input  wire logic [7:0]           slave_addr,
  input  wire logic                 read_dir,
  input  wire logic [8:0]           length,
  input  wire logic [7:0]           status_code,
  input  wire logic [7:0]           rx_byte,
  input  wire logic [7:0]           tx_byte,
  input  wire logic                 q_full,
  output logic                      push,
  output tmes_pkg::tmes_item_t      push_item
);
  import tmes_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.mode       = mode;
    push_item.slave_addr = slave_addr;
    push_item.read_dir   = read_dir;
    push_item.length     = (length > MAX_LEN) ? MAX_LEN : length;
    push_item.ev_class   = classify(status_code);
    push_item.rx_byte    = rx_byte;
    push_item.tx_byte    = tx_byte;
  end

endmodule
`default_nettype wire

FILE: design/tmes_queue.sv
`default_nettype none
module tmes_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tmes_pkg::tmes_item_t push_item,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output tmes_pkg::tmes_item_t      q_item
);
  import tmes_pkg::*;

  tmes_item_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/tmes_back.sv
`default_nettype none
module tmes_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 q_valid,
  input  wire tmes_pkg::tmes_item_t q_item,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output tmes_pkg::tmes_result_t    result
);
  import tmes_pkg::*;

  logic [7:0]   control_bits, control_bits_next;
  logic [8:0]   address_byte, address_byte_next;
  logic [8:0]   bytes_left, bytes_left_next;
  logic [7:0]   byte_position, byte_position_next;
  logic         first_read_pending, first_read_pending_next;
  tmes_result_t r;
  logic         stop;

  // The output register frees itself in the same cycle it is taken.
  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    control_bits_next       = control_bits;
    address_byte_next       = address_byte;
    bytes_left_next         = bytes_left;
    byte_position_next      = byte_position;
    first_read_pending_next = first_read_pending;
    r    = '0;
    stop = 1'b0;
    if (!q_item.mode) begin
      bytes_left_next         = q_item.length;
      byte_position_next      = 8'd0;
      first_read_pending_next = 1'b1;
      control_bits_next       = control_bits | CB_INT_EN;
      address_byte_next       = {q_item.slave_addr, q_item.read_dir};
      r.ctrl_write            = 1'b1;
      r.ctrl_value            = control_bits_next | CB_START;
    end else begin
      case (q_item.ev_class)
        EV_START: begin
          control_bits_next = control_bits & ~CB_IFLAG;
          r.data_write      = 1'b1;
          r.data_value      = address_byte;
          r.ctrl_write      = 1'b1;
          r.ctrl_value      = control_bits_next;
        end
        EV_WRITE: begin
          if (bytes_left == 9'd0) begin
            stop     = 1'b1;
            r.msg_ok = 1'b1;
          end else begin
            control_bits_next  = control_bits & ~CB_IFLAG;
            r.data_write       = 1'b1;
            r.data_value       = {1'b0, q_item.tx_byte};
            r.ctrl_write       = 1'b1;
            r.ctrl_value       = control_bits_next;
            byte_position_next = byte_position + 8'd1;
            bytes_left_next    = bytes_left - 9'd1;
          end
        end
        EV_READ: begin
          if (first_read_pending) begin
            // ACK goes out once and is not kept in the control bits.
            r.ctrl_write            = 1'b1;
            r.ctrl_value            = control_bits | CB_ACK;
            first_read_pending_next = 1'b0;
          end else if (bytes_left == 9'd0) begin
            stop     = 1'b1;
            r.msg_ok = 1'b1;
          end else begin
            control_bits_next  = control_bits & ~CB_IFLAG;
            r.rx_store         = 1'b1;
            r.rx_index         = byte_position;
            r.rx_value         = q_item.rx_byte;
            r.ctrl_write       = 1'b1;
            r.ctrl_value       = control_bits_next;
            byte_position_next = byte_position + 8'd1;
            bytes_left_next    = bytes_left - 9'd1;
          end
        end
        EV_RNACK: begin
          stop     = 1'b1;
          r.msg_ok = 1'b1;
        end
        EV_NODEV: begin
          stop = 1'b1;
        end
        default: begin
          control_bits_next = control_bits | CB_BUS_EN;
          stop              = 1'b1;
          r.bus_reinit      = 1'b1;
        end
      endcase
      if (stop) begin
        r.ctrl_write = 1'b1;
        r.ctrl_value = control_bits_next | CB_STOP;
        r.msg_done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_bits       <= CB_BUS_EN;
      address_byte       <= 9'd0;
      bytes_left         <= 9'd0;
      byte_position      <= 8'd0;
      first_read_pending <= 1'b0;
      out_valid          <= 1'b0;
    end else begin
      if (pop) begin
        control_bits       <= control_bits_next;
        address_byte       <= address_byte_next;
        bytes_left         <= bytes_left_next;
        byte_position      <= byte_position_next;
        first_read_pending <= first_read_pending_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= r;
    end
  end

endmodule
`default_nettype wire

FILE: design/twi_master_event_sequencer.sv
// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | mode, slave_addr, read_dir, length, status_code,
//         |                      | rx_byte, tx_byte
// output  | out_valid / out_ready| ctrl_write .. bus_reinit, one result per request
//
// One request per cycle is taken while the queue has room; each result passes through
// a queue entry and then the output register.
// The front classifies the status code and clamps the length into a two-entry queue.
// The back updates the message state and loads the output register in the same cycle.
// Reset (rst, synchronous) empties the queue and restores the message state.
// A stalled output holds the back; the queue keeps the input open for two more requests.
`default_nettype none
module twi_master_event_sequencer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       mode,
  input  wire logic [7:0] slave_addr,
  input  wire logic       read_dir,
  input  wire logic [8:0] length,
  input  wire logic [7:0] status_code,
  input  wire logic [7:0] rx_byte,
  input  wire logic [7:0] tx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            ctrl_write,
  output logic [7:0]      ctrl_value,
  output logic            data_write,
  output logic [8:0]      data_value,
  output logic            rx_store,
  output logic [7:0]      rx_index,
  output logic [7:0]      rx_value,
  output logic            msg_done,
  output logic            msg_ok,
  output logic            bus_reinit
);
  import tmes_pkg::*;

  logic         q_full;
  logic         push;
  tmes_item_t   push_item;
  logic         pop;
  logic         q_valid;
  tmes_item_t   q_item;
  tmes_result_t result;

  tmes_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .slave_addr  (slave_addr),
    .read_dir    (read_dir),
    .length      (length),
    .status_code (status_code),
    .rx_byte     (rx_byte),
    .tx_byte     (tx_byte),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  tmes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  tmes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign ctrl_write = result.ctrl_write;
  assign ctrl_value = result.ctrl_value;
  assign data_write = result.data_write;
  assign data_value = result.data_value;
  assign rx_store   = result.rx_store;
  assign rx_index   = result.rx_index;
  assign rx_value   = result.rx_value;
  assign msg_done   = result.msg_done;
  assign msg_ok     = result.msg_ok;
  assign bus_reinit = result.bus_reinit;

endmodule
`default_nettype wire

FILE: design/tmes_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tmes_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       ctrl_write,
  input wire logic [7:0] ctrl_value,
  input wire logic       data_write,
  input wire logic [8:0] data_value,
  input wire logic       msg_done,
  input wire logic       msg_ok,
  input wire logic       bus_reinit
);

  // A result waiting for the consumer is not withdrawn.
  `ASSERT_CLK_RST(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "out_valid dropped")

  // A finished message always comes with a STOP in the control write.
  `ASSERT_CLK_RST(a_done_stop, clk, rst, out_valid && msg_done |-> ctrl_write && ctrl_value[4], "done without STOP")

  // A re-init request is a failed, finished message.
  `ASSERT_CLK_RST(a_reinit, clk, rst, out_valid && bus_reinit |-> msg_done && !msg_ok, "bad re-init result")

  // Bus enable is never cleared, so every control write carries it.
  `ASSERT_CLK_RST(a_bus_en, clk, rst, out_valid && ctrl_write |-> ctrl_value[6], "bus enable missing")

  `ASSERT_CLK_RST(a_data_zero, clk, rst, out_valid && !data_write |-> data_value == 9'd0, "stray data value")

endmodule

bind twi_master_event_sequencer tmes_checker u_tmes_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ctrl_write (ctrl_write),
  .ctrl_value (ctrl_value),
  .data_write (data_write),
  .data_value (data_value),
  .msg_done   (msg_done),
  .msg_ok     (msg_ok),
  .bus_reinit (bus_reinit)
);
`default_nettype wire
